/* hdl/dds_pkg.sv */
// ----------------------------------------------------------------------------
// dds_pkg: shared definitions for the discrete distribution sampler
// Op codes, field widths and default sizes used by every file of the block but the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

  // Field widths fixed by the item format
  localparam int OP_W    = 2;
  localparam int LABEL_W = 32;

  // Default sizes handed to the top level parameters
  localparam int DEF_MAX_ENTRIES   = 64;
  localparam int DEF_FRACTION_BITS = 16;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Op codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAW   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

endpackage

`default_nettype wire

/* hdl/dds_if.sv */
// ----------------------------------------------------------------------------
// dds_if: valid/ready channels of the discrete distribution sampler
// Input channel carries op beats, output channel carries sample beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface dds_in_if
  import dds_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
);
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [LABEL_W-1:0]  entry_label;
  logic [FRACTION_BITS:0]     entry_weight;
  logic [FRACTION_BITS:0]     uniform_draw;

  modport source (output valid, op, entry_label, entry_weight, uniform_draw,
                  input ready);
  modport sink   (input valid, op, entry_label, entry_weight, uniform_draw,
                  output ready);
endinterface

interface dds_out_if
  import dds_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
);
  localparam int IDX_W = $clog2(MAX_ENTRIES);

  logic                       valid;
  logic                       ready;
  logic signed [LABEL_W-1:0]  sample_label;
  logic [IDX_W-1:0]           sample_index;
  logic                       beyond_total;
  logic                       table_empty;

  modport source (output valid, sample_label, sample_index, beyond_total, table_empty,
                  input ready);
  modport sink   (input valid, sample_label, sample_index, beyond_total, table_empty,
                  output ready);
endinterface

`default_nettype wire

/* hdl/dds_ram.sv */
// ----------------------------------------------------------------------------
// dds_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read, data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/dds_front.sv */
// ----------------------------------------------------------------------------
// dds_front: input acceptance and command queue
// Takes input beats, drops unused op codes and queues commands for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_front
  import dds_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  dds_in_if.sink                          in_bus,
  output logic                            cmd_valid,
  input  wire logic                       cmd_ready,
  output logic [OP_W-1:0]                 cmd_op,
  output logic signed [LABEL_W-1:0]       cmd_label,
  output logic [FRACTION_BITS:0]          cmd_weight,
  output logic [FRACTION_BITS:0]          cmd_draw
);

  localparam int VAL_W   = FRACTION_BITS + 1;
  localparam int ENTRY_W = OP_W + LABEL_W + 2 * VAL_W;
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);

  logic [ENTRY_W-1:0] q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               push, pop;
  logic [ENTRY_W-1:0] head;

  // Accept whenever the queue has room; unused op codes are dropped here
  assign in_bus.ready = (fill_r != FILL_W'(QUEUE_DEPTH));
  assign push = in_bus.valid && in_bus.ready && (in_bus.op != OP_NONE);
  assign pop  = cmd_valid && cmd_ready;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= {in_bus.op, in_bus.entry_label, in_bus.entry_weight,
                        in_bus.uniform_draw};
    end
  end

  // Present the head command
  assign head      = q_r[rd_ptr_r];
  assign cmd_valid = (fill_r != '0);
  assign cmd_op     = head[ENTRY_W-1 -: OP_W];
  assign cmd_label  = head[2*VAL_W +: LABEL_W];
  assign cmd_weight = head[VAL_W +: VAL_W];
  assign cmd_draw   = head[0 +: VAL_W];

endmodule

`default_nettype wire

/* hdl/dds_back.sv */
// ----------------------------------------------------------------------------
// dds_back: table update and binary search engine
// Executes clear, append and draw commands; a draw runs a binary search over
// the cumulative sums, one compare per cycle, then reads the chosen label.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_back
  import dds_pkg::*;
#(
  parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cmd_valid,
  output logic                                cmd_ready,
  input  wire logic [OP_W-1:0]                cmd_op,
  input  wire logic signed [LABEL_W-1:0]      cmd_label,
  input  wire logic [FRACTION_BITS:0]         cmd_weight,
  input  wire logic [FRACTION_BITS:0]         cmd_draw,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [LABEL_W-1:0]           out_label,
  output logic [$clog2(MAX_ENTRIES)-1:0]      out_index,
  output logic                                out_beyond,
  output logic                                out_empty
);

  localparam int VAL_W = FRACTION_BITS + 1;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = $clog2(2 * MAX_ENTRIES) + FRACTION_BITS;
  localparam logic [SUM_W:0] SUM_MAX =
    (SUM_W + 1)'((64'(2 * MAX_ENTRIES) << FRACTION_BITS) - 64'd1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [SUM_W-1:0]        total_r, total_nxt;
  logic [CNT_W-1:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]        hi_r, hi_nxt;
  logic [IDX_W-1:0]        mid_r, mid_nxt;
  logic [VAL_W-1:0]        draw_r, draw_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    beyond_r, beyond_nxt;
  logic                    empty_r, empty_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [LABEL_W-1:0] out_label_r;
  logic [IDX_W-1:0]        out_index_r;
  logic                    out_beyond_r, out_empty_r;
  logic                    out_load;

  // RAM ports
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [SUM_W-1:0]        wr_sum;
  logic                    cum_rd_en;
  logic [IDX_W-1:0]        cum_rd_addr;
  logic [SUM_W-1:0]        cum_rd_data;
  logic                    lab_rd_en;
  logic [IDX_W-1:0]        lab_rd_addr;
  logic [LABEL_W-1:0]      lab_rd_data;

  // Datapath helpers
  logic [SUM_W:0]          sum_ext;
  logic [CNT_W-1:0]        count_half;
  logic                    lt;
  logic [CNT_W-1:0]        lo_step, hi_step;
  logic [CNT_W:0]          span_sum, span_half;
  logic                    step_done;
  logic                    clamp;
  logic [CNT_W-1:0]        pick;

  dds_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ENTRIES)) u_cum_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_sum),
    .rd_en   (cum_rd_en),
    .rd_addr (cum_rd_addr),
    .rd_data (cum_rd_data)
  );

  dds_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_ENTRIES)) u_label_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd_label),
    .rd_en   (lab_rd_en),
    .rd_addr (lab_rd_addr),
    .rd_data (lab_rd_data)
  );

  // Saturating running sum for an append
  assign sum_ext = {1'b0, total_r} + (SUM_W + 1)'(cmd_weight);
  assign wr_sum  = (sum_ext > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_ext[SUM_W-1:0];
  assign wr_addr = count_r[IDX_W-1:0];

  // One search step: narrow [lo, hi) around the compared midpoint
  assign count_half = count_r >> 1;
  assign lt         = (cum_rd_data < (SUM_W)'(draw_r));
  assign lo_step    = lt ? (CNT_W'(mid_r) + CNT_W'(1)) : lo_r;
  assign hi_step    = lt ? hi_r : CNT_W'(mid_r);
  assign span_sum   = {1'b0, lo_step} + {1'b0, hi_step};
  assign span_half  = span_sum >> 1;
  assign step_done  = (lo_step >= hi_step);
  assign clamp      = (lo_step >= count_r);
  assign pick       = clamp ? (count_r - CNT_W'(1)) : lo_step;

  assign cmd_ready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // Sequence commands
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    draw_nxt    = draw_r;
    idx_nxt     = idx_r;
    beyond_nxt  = beyond_r;
    empty_nxt   = empty_r;
    wr_en       = 1'b0;
    cum_rd_en   = 1'b0;
    cum_rd_addr = mid_r;
    lab_rd_en   = 1'b0;
    lab_rd_addr = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd_op)
            OP_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
            end
            OP_APPEND: begin
              if (count_r < CNT_W'(MAX_ENTRIES)) begin
                wr_en     = 1'b1;
                total_nxt = wr_sum;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_DRAW: begin
              draw_nxt   = cmd_draw;
              beyond_nxt = 1'b0;
              if (count_r == '0) begin
                empty_nxt = 1'b1;
                state_nxt = ST_OUT;
              end else begin
                empty_nxt   = 1'b0;
                lo_nxt      = '0;
                hi_nxt      = count_r;
                mid_nxt     = count_half[IDX_W-1:0];
                cum_rd_en   = 1'b1;
                cum_rd_addr = count_half[IDX_W-1:0];
                state_nxt   = ST_CMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CMP: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        if (step_done) begin
          idx_nxt     = pick[IDX_W-1:0];
          beyond_nxt  = clamp;
          lab_rd_en   = 1'b1;
          lab_rd_addr = pick[IDX_W-1:0];
          state_nxt   = ST_OUT;
        end else begin
          mid_nxt     = span_half[IDX_W-1:0];
          cum_rd_en   = 1'b1;
          cum_rd_addr = span_half[IDX_W-1:0];
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold a result until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    draw_r   <= draw_nxt;
    idx_r    <= idx_nxt;
    beyond_r <= beyond_nxt;
    empty_r  <= empty_nxt;
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_label_r  <= empty_r ? '0 : lab_rd_data;
      out_index_r  <= empty_r ? '0 : idx_r;
      out_beyond_r <= empty_r ? 1'b0 : beyond_r;
      out_empty_r  <= empty_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_label  = out_label_r;
  assign out_index  = out_index_r;
  assign out_beyond = out_beyond_r;
  assign out_empty  = out_empty_r;

endmodule

`default_nettype wire

/* hdl/discrete_distribution_sampler.sv */
// ----------------------------------------------------------------------------
// discrete_distribution_sampler: inverse cumulative distribution sampler
// Clear and append wait in the command queue, then execute in the back end.
// A draw runs a binary search over the n loaded entries, one cumulative
// RAM read and compare per cycle, then reads the chosen label.
// One draw is in the search at a time; a finished sample waits in an output
// register while new beats are queued. Reset empties the table and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module discrete_distribution_sampler
  import dds_pkg::*;
#(
  parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dds_in_if.sink    in_bus,
  dds_out_if.source out_bus
);

  logic                          cmd_valid;
  logic                          cmd_ready;
  logic [OP_W-1:0]               cmd_op;
  logic signed [LABEL_W-1:0]     cmd_label;
  logic [FRACTION_BITS:0]        cmd_weight;
  logic [FRACTION_BITS:0]        cmd_draw;

  // Accept and queue commands
  dds_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_op     (cmd_op),
    .cmd_label  (cmd_label),
    .cmd_weight (cmd_weight),
    .cmd_draw   (cmd_draw)
  );

  // Execute commands and produce samples
  dds_back #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_op     (cmd_op),
    .cmd_label  (cmd_label),
    .cmd_weight (cmd_weight),
    .cmd_draw   (cmd_draw),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_label  (out_bus.sample_label),
    .out_index  (out_bus.sample_index),
    .out_beyond (out_bus.beyond_total),
    .out_empty  (out_bus.table_empty)
  );

  // An empty-table beat carries index zero and no clamp flag
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.table_empty |->
      (out_bus.sample_index == '0) && !out_bus.beyond_total)
    else $error("empty-table sample carries index or clamp flag");

  // A popped draw keeps the back busy in the following cycle
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && cmd_ready && (cmd_op == OP_DRAW) |=> !cmd_ready)
    else $error("back accepted a command during a draw");

  // No result beat right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
